@@ rtl/mdet_pkg.sv @@
// Shared types and constants for the matrix determinant block.
package mdet_pkg;

    // Largest matrix side that the store and the permutation table cover.
    localparam int MaxSize = 4;
    localparam int Cells   = MaxSize * MaxSize;
    localparam int PermCount = 24;

    localparam logic [4:0] PermLast = 5'd23;

    // Width of the exact determinant of 4x4 raw 16-bit entries (24 terms of up to 2^60).
    localparam int AccWidth  = 66;
    // Accumulator after the Q32.32 alignment shift of up to 24 bits.
    localparam int WideWidth = AccWidth + 24;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PROD,
        ST_ACC,
        ST_CONV
    } t_state;

    // Column picked in rows 0..3 for each permutation, row 0 in the top two bits.
    // The permutations are listed in lexicographic order.
    localparam logic [7:0] PermCols [PermCount] = '{
        8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
        8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
        8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
        8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
        8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
        8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
    };

    // Bit p is set when permutation p is odd; in lexicographic order the
    // parity follows the pattern even, odd, odd, even.
    localparam logic [PermCount-1:0] PermOdd = 24'h666666;

    function automatic logic [1:0] perm_col(input logic [4:0] perm, input logic [1:0] row);
        logic [7:0] cols;
        cols = PermCols[perm];
        case (row)
            2'd0:    perm_col = cols[7:6];
            2'd1:    perm_col = cols[5:4];
            2'd2:    perm_col = cols[3:2];
            default: perm_col = cols[1:0];
        endcase
    endfunction

endpackage

@@ rtl/matrix_determinant.sv @@
// Determinant of a square Q8.8 matrix on one shared multiplier, result in saturated Q32.32.
//
// The block takes the entries of an n x n matrix (n = matrix_size, 1 to 4; a size of 0 acts
// as 1 and sizes above 4 act as 4) one per transfer in row-major order, one transfer per
// cycle while loading. After the last entry the input stalls and the determinant is formed
// by full expansion over all 24 permutations of a 4x4 frame: this is the Laplace cofactor
// expansion along the first row carried down to single entries. A smaller matrix sits in
// the top-left corner of that frame with an identity block padding the rest, so every
// size runs the same sequence. Each permutation runs on the single signed 48 x 16
// multiplier in four multiply steps, each entry being fetched from the register store in
// the step before its multiply, then one add or subtract into a 66-bit exact accumulator.
// After all permutations the result is aligned to Q32.32 (shift left by 32 - 8n, exact)
// and clamped to 64 bits; saturated flags a clamp. The result sits in an output register,
// so loading of the next matrix goes on while it waits to be taken; the block holds in its
// final step only if a new result is ready before the previous one has been transferred.
// Writing matrix_size discards any partly loaded matrix and starts loading afresh; it is
// meant to happen only while no computation is under way.
module matrix_determinant
    import mdet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_element,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_determinant,
    output logic               o_saturated
);

    t_state r_state, n_state;

    logic [2:0]  r_size;
    logic [4:0]  r_count;
    logic [4:0]  r_perm;
    logic [2:0]  r_k;
    logic signed [15:0] r_store [Cells];
    logic signed [15:0] r_rd;
    logic signed [63:0] r_prod;
    logic signed [AccWidth-1:0] r_acc;
    logic        r_out_valid;
    logic signed [63:0] r_out_det;
    logic        r_out_sat;

    logic [2:0]  w_n;
    logic [4:0]  w_total;
    logic        w_in_acc;
    logic        w_last;
    logic        w_start;
    logic        w_conv_go;
    logic [1:0]  w_row;
    logic [1:0]  w_col;
    logic [3:0]  w_idx;
    logic        w_in_frame;
    logic signed [63:0] w_mul;
    logic signed [AccWidth-1:0] w_term;
    logic signed [WideWidth-1:0] w_wide;
    logic        w_fits;

    // Effective matrix side.
    always_comb begin
        case (r_size)
            3'd0:    w_n = 3'd1;
            3'd1:    w_n = 3'd1;
            3'd2:    w_n = 3'd2;
            3'd3:    w_n = 3'd3;
            default: w_n = 3'd4;
        endcase
    end

    assign w_total  = 5'(w_n) * 5'(w_n);
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_last   = (r_count + 5'd1) == w_total;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (!i_cfg_we && w_in_acc && w_last) begin
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                if (r_k == 3'd4) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_perm == PermLast) begin
                    n_state = ST_CONV;
                end else begin
                    n_state = ST_PROD;
                end
            end
            ST_CONV: begin
                if (w_conv_go) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_start    = 1'b0;
        w_conv_go  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                w_start    = !i_cfg_we && w_in_acc && w_last;
            end
            ST_PROD: o_in_stall = 1'b1;
            ST_ACC:  o_in_stall = 1'b1;
            ST_CONV: w_conv_go  = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Entry address for the current multiply step; outside the n x n corner the
    // frame holds the identity.
    assign w_row      = r_k[1:0];
    assign w_col      = perm_col(r_perm, w_row);
    assign w_in_frame = (3'(w_row) < w_n) && (3'(w_col) < w_n);
    assign w_idx      = 4'(w_row) * 4'(w_n) + 4'(w_col);

    // Only three entries have been folded in before the last multiply, so 48 bits hold it.
    assign w_mul  = $signed(r_prod[47:0]) * r_rd;
    assign w_term = AccWidth'(r_prod);

    // Q32.32 alignment: the exact determinant carries 8n fractional bits.
    always_comb begin
        case (w_n)
            3'd1:    w_wide = WideWidth'(r_acc) <<< 24;
            3'd2:    w_wide = WideWidth'(r_acc) <<< 16;
            3'd3:    w_wide = WideWidth'(r_acc) <<< 8;
            default: w_wide = WideWidth'(r_acc);
        endcase
    end

    assign w_fits = w_wide[WideWidth-1:63] == {(WideWidth - 63){w_wide[WideWidth-1]}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_size      <= 3'd4;
            r_count     <= 5'd0;
            r_perm      <= 5'd0;
            r_k         <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size  <= i_cfg_data;
                r_count <= 5'd0;
            end else if (w_in_acc) begin
                r_count <= w_last ? 5'd0 : r_count + 5'd1;
            end
            if (w_start) begin
                r_perm <= 5'd0;
                r_k    <= 3'd0;
            end else if (r_state == ST_PROD) begin
                r_k <= r_k + 3'd1;
            end else if (r_state == ST_ACC) begin
                // The index rests on the last permutation until the next matrix.
                if (r_perm != PermLast) begin
                    r_perm <= r_perm + 5'd1;
                end
                r_k    <= 3'd0;
            end
            if (w_conv_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Matrix store and its registered read port.
    always_ff @(posedge i_clk) begin
        if (!i_cfg_we && w_in_acc) begin
            r_store[r_count[3:0]] <= i_element;
        end
        if (r_state == ST_PROD && r_k != 3'd4) begin
            if (w_in_frame) begin
                r_rd <= r_store[w_idx];
            end else begin
                r_rd <= (w_row == w_col) ? 16'sd1 : 16'sd0;
            end
        end
    end

    // Product and accumulator datapath.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_acc <= '0;
        end
        if (r_state == ST_PROD) begin
            if (r_k == 3'd0) begin
                r_prod <= 64'sd1;
            end else begin
                r_prod <= w_mul;
            end
        end
        if (r_state == ST_ACC) begin
            if (PermOdd[r_perm]) begin
                r_acc <= r_acc - w_term;
            end else begin
                r_acc <= r_acc + w_term;
            end
        end
        if (w_conv_go) begin
            if (w_fits) begin
                r_out_det <= w_wide[63:0];
                r_out_sat <= 1'b0;
            end else begin
                r_out_det <= w_wide[WideWidth-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                r_out_sat <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_determinant = r_out_det;
    assign o_saturated   = r_out_sat;

    // The load counter always stays below the entry count of the current size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < w_total)
        else $error("load counter beyond matrix size");

    // Conversion is reached only after the last permutation has been added in.
    a_conv_after_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> (r_perm == PermLast))
        else $error("conversion before all permutations were summed");

    // The multiply step counter never passes the fourth entry.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROD) |-> (r_k <= 3'd4))
        else $error("multiply step counter out of range");

    // A clamped result is one of the two range limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_determinant == {1'b1, 63'd0} || o_determinant == {1'b0, {63{1'b1}}}))
        else $error("saturated result is not a range limit");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the matrix determinant block with a scoreboard class.
`timescale 1ns / 100ps

// Tracks the size setting and the partly loaded matrix. On each full matrix it
// computes the saturated Q32.32 determinant and queues it. Each result that the
// block hands over is then compared against the oldest queued determinant.
class det_scoreboard;

    localparam int TopSide = 4;

    int unsigned size_setting;
    int unsigned loaded;
    logic signed [15:0] cells [TopSide*TopSide];
    logic signed [63:0] det_expected [$];
    bit sat_expected [$];
    int errors;

    function new();
        size_setting = 4;
        loaded = 0;
        errors = 0;
    endfunction

    // A size of zero behaves as one, and anything above four behaves as four.
    function int unsigned side();
        if (size_setting == 0)
            return 1;
        if (size_setting > TopSide)
            return TopSide;
        return size_setting;
    endfunction

    function int pending();
        return det_expected.size();
    endfunction

    // A size write throws away any partly loaded matrix.
    function void note_config(logic [2:0] value);
        size_setting = value;
        loaded = 0;
    endfunction

    // Exact integer determinant of the raw entries. The matrix is padded to 4x4
    // with an identity block, and all permutations are summed, which is the
    // cofactor expansion along the first row carried down to single entries.
    function logic signed [127:0] exact_det(int unsigned n);
        logic signed [127:0] acc;
        logic signed [127:0] term;
        logic signed [127:0] entry_val;
        int col [TopSide];
        int a, b, c, d, r, j, inv;
        bit ok;
        acc = '0;
        for (a = 0; a < TopSide; a++)
        for (b = 0; b < TopSide; b++)
        for (c = 0; c < TopSide; c++)
        for (d = 0; d < TopSide; d++) begin
            col[0] = a;
            col[1] = b;
            col[2] = c;
            col[3] = d;
            ok = (((1 << a) | (1 << b) | (1 << c) | (1 << d)) == 15);
            for (r = n; r < TopSide; r++)
                if (col[r] != r)
                    ok = 1'b0;
            if (ok) begin
                inv = 0;
                term = 128'sd1;
                for (r = 0; r < TopSide; r++) begin
                    for (j = r + 1; j < TopSide; j++)
                        if (col[r] > col[j])
                            inv++;
                    if (r < n) begin
                        entry_val = cells[r*n + col[r]];
                        term = term * entry_val;
                    end
                end
                if (inv % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        return acc;
    endfunction

    function void note_element(logic signed [15:0] value);
        logic signed [127:0] scaled;
        logic signed [127:0] q_max;
        logic signed [127:0] q_min;
        int unsigned n;
        n = side();
        cells[loaded] = value;
        loaded++;
        if (loaded == n * n) begin
            loaded = 0;
            // Q8.8 entries give 8n fractional bits; align to 32 (exact for n <= 4).
            scaled = exact_det(n) <<< (32 - 8 * n);
            q_max = 128'sh7FFF_FFFF_FFFF_FFFF;
            q_min = -q_max - 128'sd1;
            if (scaled > q_max) begin
                det_expected.push_back(64'sh7FFF_FFFF_FFFF_FFFF);
                sat_expected.push_back(1'b1);
            end else if (scaled < q_min) begin
                det_expected.push_back(64'sh8000_0000_0000_0000);
                sat_expected.push_back(1'b1);
            end else begin
                det_expected.push_back(scaled[63:0]);
                sat_expected.push_back(1'b0);
            end
        end
    endfunction

    function void check_result(logic signed [63:0] det, logic sat);
        logic signed [63:0] want_det;
        bit want_sat;
        if (det_expected.size() == 0) begin
            if (errors < 10)
                $display("%0t: determinant %0d (saturated %0b) with none expected",
                         $realtime, det, sat);
            errors++;
        end else begin
            want_det = det_expected.pop_front();
            want_sat = sat_expected.pop_front();
            if (det !== want_det || sat !== want_sat) begin
                if (errors < 10)
                    $display("%0t: determinant %0d saturated %0b, expected %0d saturated %0b",
                             $realtime, det, sat, want_det, want_sat);
                errors++;
            end
        end
    endfunction

endclass

module testbench;

    // Cycles the block may still spend finishing a determinant.
    localparam int SettleCycles = 200;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HoldCycles = 1000;
    // Cycles without any transfer before the run is declared hung.
    localparam int QuietLimit = 20000;
    localparam int PhaseItems = 180;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_element;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [63:0] o_determinant;
    logic               o_saturated;

    det_scoreboard sb;

    // Percent chances of an idle sender cycle and a stalled receiver cycle.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    matrix_determinant dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_element     (i_element),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_determinant (o_determinant),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offers one element, possibly after some idle cycles, and returns at the
    // edge where the transfer takes place. Valid stays high on return, so back to
    // back transfers never lower and raise it within one step.
    task automatic offer_element(input logic signed [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_element  <= value;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_element(value);
    endtask

    // Stops offering, waits for every queued determinant to come out, then lets
    // the block finish whatever it may still be computing.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Writes the size register; only called with the block idle.
    task automatic write_size(input logic [2:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.note_config(value);
    endtask

    // Element content follows a per-matrix flavor: full random words, only the
    // two extremes with random signs (which drives 4x4 results into saturation),
    // small values near zero, or a mixture of all of these.
    function automatic logic signed [15:0] pick_element(input int flavor);
        logic signed [15:0] value;
        int pick;
        pick = (flavor == 3) ? $urandom_range(2) : flavor;
        case (pick)
            1: begin
                value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            2: begin
                value = 16'($urandom_range(1023));
                value = value - 16'sd512;
            end
            default: begin
                value = 16'($urandom_range(65535));
            end
        endcase
        return value;
    endfunction

    // The receiver stalls at random at the current rate, except for one long
    // hold-off on request, which is counted here in its own loop.
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Every determinant transfer is checked against the oldest queued one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_determinant, o_saturated);
    end

    // Watchdog: the run is hung if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [15:0] hadamard_neg;
        logic [2:0]  phase_sizes [10];
        int phase, k, n, flavor;

        phase_sizes = '{3'd4, 3'd3, 3'd0, 3'd2, 3'd7, 3'd1, 3'd5, 3'd6, 3'd4, 3'd3};
        // Sign pattern of a 4x4 Hadamard matrix, row-major, a set bit marks -1.
        hadamard_neg = 16'b0000_0101_0011_0110;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_element  <= '0;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset size of 4: a Hadamard pattern scaled to the
        // extremes has a determinant near 2^64 and must clamp to the positive limit.
        for (k = 0; k < 16; k++)
            offer_element(hadamard_neg[15-k] ? 16'sh8000 : 16'sh7FFF);

        // Size 1: each element is its own determinant, extremes and sign included.
        settle();
        write_size(3'd1);
        offer_element(16'sd0);
        offer_element(16'sh7FFF);
        offer_element(16'sh8000);
        offer_element(-16'sd1);

        // Size 2 with extreme entries: a*d - b*c at the edge of its range.
        settle();
        write_size(3'd2);
        offer_element(16'sh8000);
        offer_element(16'sh7FFF);
        offer_element(16'sh7FFF);
        offer_element(16'sh8000);

        // Random phases. Each one sets a size (0 and values above 4 included) and
        // an idling mode; a phase of side 4 ends with a partly loaded matrix that the
        // next size write drops. The block is drained before every write.
        for (phase = 0; phase < 10; phase++) begin
            settle();
            write_size(phase_sizes[phase]);
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            // Long hold-off on a 4x4 phase with a busy sender, so that the
            // output register and the next computation fill and the input stalls.
            if (phase == 8)
                hold_request = 1'b1;
            n = sb.side();
            flavor = 0;
            for (k = 0; k < PhaseItems; k++) begin
                if (k % (n * n) == 0)
                    flavor = $urandom_range(3);
                offer_element(pick_element(flavor));
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
